/* rtl/core/csf_pkg.sv */
// Shared types, constants and the byte rendering function of the cat stream filter.
package csf_pkg;

   localparam int CSR_ADDR_W = 5;
   localparam int CSR_DATA_W = 32;
   localparam int SEQ_DEPTH  = 11;
   localparam int NUM_CHARS  = 7;
   localparam int REND_MAX   = 4;
   localparam int DIGITS     = 6;

   // register indexes
   localparam logic [2:0] REG_NUM_ALL      = 3'd0;
   localparam logic [2:0] REG_NUM_NONBLANK = 3'd1;
   localparam logic [2:0] REG_SQUEEZE      = 3'd2;
   localparam logic [2:0] REG_SHOW_ENDS    = 3'd3;
   localparam logic [2:0] REG_SHOW_TABS    = 3'd4;
   localparam logic [2:0] REG_NONPRINT     = 3'd5;

   // character codes
   localparam logic [7:0] CH_TAB    = 8'h09;
   localparam logic [7:0] CH_NL     = 8'h0A;
   localparam logic [7:0] CH_SPACE  = 8'h20;
   localparam logic [7:0] CH_DOLLAR = 8'h24;
   localparam logic [7:0] CH_DASH   = 8'h2D;
   localparam logic [7:0] CH_ZERO   = 8'h30;
   localparam logic [7:0] CH_QMARK  = 8'h3F;
   localparam logic [7:0] CH_I      = 8'h49;
   localparam logic [7:0] CH_M      = 8'h4D;
   localparam logic [7:0] CH_CARET  = 8'h5E;
   localparam logic [7:0] CH_DEL    = 8'h7F;
   localparam logic [7:0] CTRL_TOP  = 8'd32;
   localparam logic [7:0] CTRL_OFS  = 8'd64;
   localparam logic [3:0] BCD_NINE  = 4'd9;

   typedef struct packed {
      logic number_all_lines;
      logic number_nonblank_lines;
      logic squeeze_blank_lines;
      logic show_line_ends;
      logic show_tab_chars;
      logic show_nonprinting;
   } cfg_type;

   typedef logic [SEQ_DEPTH-1:0][7:0] seq_type;

   typedef struct packed {
      seq_type    seq;
      logic [3:0] cnt;
   } job_type;

   typedef struct packed {
      logic busy;
      logic finishing;
   } emit_status_type;

   typedef struct packed {
      logic [REND_MAX-1:0][7:0] bytes;
      logic [2:0]               cnt;
   } rend_type;

   function automatic rend_type render(input logic [7:0] b, input cfg_type cfg);
      rend_type        r;
      logic [7:0]      lo;
      logic [1:0][7:0] t;
      logic [1:0]      tc;
      r        = '0;
      r.cnt    = 3'd1;
      r.bytes[0] = b;
      lo       = {1'b0, b[6:0]};
      t        = '0;
      tc       = 2'd1;
      if (b == CH_TAB) begin
         if (cfg.show_tab_chars) begin
            r.bytes[0] = CH_CARET;
            r.bytes[1] = CH_I;
            r.cnt      = 3'd2;
         end
      end else if (b == CH_NL) begin
         if (cfg.show_line_ends) begin
            r.bytes[0] = CH_DOLLAR;
            r.bytes[1] = CH_NL;
            r.cnt      = 3'd2;
         end
      end else if (cfg.show_nonprinting) begin
         t[0] = lo;
         if (lo < CTRL_TOP) begin
            t[0] = CH_CARET;
            t[1] = lo + CTRL_OFS;
            tc   = 2'd2;
         end else if (lo == CH_DEL) begin
            t[0] = CH_CARET;
            t[1] = CH_QMARK;
            tc   = 2'd2;
         end
         if (b[7]) begin
            r.bytes[0] = CH_M;
            r.bytes[1] = CH_DASH;
            r.bytes[2] = t[0];
            r.bytes[3] = t[1];
            r.cnt      = 3'd2 + {1'b0, tc};
         end else begin
            r.bytes[1:0] = t;
            r.cnt        = {1'b0, tc};
         end
      end
      return r;
   endfunction

endpackage

/* rtl/core/csf_csr.sv */
// Configuration registers behind the APB-style port.
module csf_csr
   import csf_pkg::*;
(
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  csr_psel,
   input  logic                  csr_penable,
   input  logic                  csr_pwrite,
   input  logic [CSR_ADDR_W-1:0] csr_paddr,
   input  logic [CSR_DATA_W-1:0] csr_pwdata,
   output logic [CSR_DATA_W-1:0] csr_prdata,
   output logic                  csr_pready,
   output cfg_type               cfg
);

   cfg_type    cfg_ff, cfg_in;
   logic [2:0] idx;
   logic       wr;
   logic       rd_bit;

   assign idx        = csr_paddr[4:2];
   assign wr         = csr_psel && csr_penable && csr_pwrite;
   assign csr_pready = 1'b1;
   assign cfg        = cfg_ff;

   always_comb begin
      cfg_in = cfg_ff;
      if (wr) begin
         case (idx)
            REG_NUM_ALL:      cfg_in.number_all_lines      = csr_pwdata[0];
            REG_NUM_NONBLANK: cfg_in.number_nonblank_lines = csr_pwdata[0];
            REG_SQUEEZE:      cfg_in.squeeze_blank_lines   = csr_pwdata[0];
            REG_SHOW_ENDS:    cfg_in.show_line_ends        = csr_pwdata[0];
            REG_SHOW_TABS:    cfg_in.show_tab_chars        = csr_pwdata[0];
            REG_NONPRINT:     cfg_in.show_nonprinting      = csr_pwdata[0];
            default:          cfg_in = cfg_ff;
         endcase
      end
   end

   always_comb begin
      case (idx)
         REG_NUM_ALL:      rd_bit = cfg_ff.number_all_lines;
         REG_NUM_NONBLANK: rd_bit = cfg_ff.number_nonblank_lines;
         REG_SQUEEZE:      rd_bit = cfg_ff.squeeze_blank_lines;
         REG_SHOW_ENDS:    rd_bit = cfg_ff.show_line_ends;
         REG_SHOW_TABS:    rd_bit = cfg_ff.show_tab_chars;
         REG_NONPRINT:     rd_bit = cfg_ff.show_nonprinting;
         default:          rd_bit = 1'b0;
      endcase
   end

   assign csr_prdata = {{(CSR_DATA_W-1){1'b0}}, rd_bit};

   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff <= '0;
      end else begin
         cfg_ff <= cfg_in;
      end
   end

endmodule

/* rtl/core/csf_front.sv */
// Input side: line state, squeeze decision, line numbering and byte sequence build.
module csf_front
   import csf_pkg::*;
(
   input  logic       clock,
   input  logic       reset,
   input  cfg_type    cfg,
   input  logic       req_tvalid,
   output logic       req_tready,
   input  logic [7:0] req_tdata,
   input  logic       req_tuser,
   input  logic       take_ok,
   output logic       job_load,
   output job_type    job
);

   logic                     after_nl_ff, after_nl_in;
   logic                     last_empty_ff, last_empty_in;
   logic [DIGITS-1:0][3:0]   bcd_ff, bcd_in;   // [0] is the units digit

   logic                     accept;
   logic                     chunk_start;
   logic                     empty;
   logic                     drop;
   logic                     numbered;
   logic                     all_nine;
   logic                     carry;
   logic                     lead;
   logic [DIGITS-1:0][3:0]   bcd_inc;
   logic [3:0]               dig;
   logic [NUM_CHARS-1:0][7:0] num_chars;
   rend_type                 rend;

   assign req_tready  = take_ok;
   assign accept      = req_tvalid && req_tready;
   assign chunk_start = req_tuser || after_nl_ff;
   assign empty       = (req_tdata == CH_NL);
   assign drop        = chunk_start && cfg.squeeze_blank_lines && last_empty_ff && empty;
   assign numbered    = after_nl_ff &&
                        (cfg.number_nonblank_lines ? !empty : cfg.number_all_lines);
   assign job_load    = accept && !drop;
   assign rend        = render(req_tdata, cfg);

   // decimal counter, saturating at all nines
   always_comb begin
      all_nine = 1'b1;
      carry    = 1'b1;
      for (int i = 0; i < DIGITS; i++) begin
         all_nine = all_nine && (bcd_ff[i] == BCD_NINE);
         if (carry) begin
            if (bcd_ff[i] == BCD_NINE) begin
               bcd_inc[i] = 4'd0;
            end else begin
               bcd_inc[i] = bcd_ff[i] + 4'd1;
               carry      = 1'b0;
            end
         end else begin
            bcd_inc[i] = bcd_ff[i];
         end
      end
      if (all_nine) begin
         bcd_inc = bcd_ff;
      end
   end

   // six right-aligned digits, leading zeros as blanks, then a tab
   always_comb begin
      lead = 1'b1;
      dig  = '0;
      for (int p = 0; p < DIGITS; p++) begin
         dig = bcd_inc[DIGITS-1-p];
         if (lead && (dig == 4'd0) && (p < DIGITS-1)) begin
            num_chars[p] = CH_SPACE;
         end else begin
            lead         = 1'b0;
            num_chars[p] = CH_ZERO + {4'd0, dig};
         end
      end
      num_chars[NUM_CHARS-1] = CH_TAB;
   end

   always_comb begin
      job.seq = '0;
      if (numbered) begin
         job.seq[NUM_CHARS-1:0]                  = num_chars;
         job.seq[NUM_CHARS+REND_MAX-1:NUM_CHARS] = rend.bytes;
         job.cnt = 4'(NUM_CHARS) + {1'b0, rend.cnt};
      end else begin
         job.seq[REND_MAX-1:0] = rend.bytes;
         job.cnt = {1'b0, rend.cnt};
      end
   end

   always_comb begin
      after_nl_in   = after_nl_ff;
      last_empty_in = last_empty_ff;
      bcd_in        = bcd_ff;
      if (job_load) begin
         after_nl_in = empty;
         if (chunk_start) begin
            last_empty_in = empty;
         end
         if (numbered) begin
            bcd_in = bcd_inc;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         after_nl_ff   <= 1'b1;
         last_empty_ff <= 1'b0;
         bcd_ff        <= '0;
      end else begin
         after_nl_ff   <= after_nl_in;
         last_empty_ff <= last_empty_in;
         bcd_ff        <= bcd_in;
      end
   end

endmodule

/* rtl/core/csf_emit.sv */
// Output side: holds one expanded item and plays it out one beat per cycle while the output is not stalled.
module csf_emit
   import csf_pkg::*;
(
   input  logic            clock,
   input  logic            reset,
   input  logic            job_load,
   input  job_type         job,
   output logic            take_ok,
   output emit_status_type status,
   output logic            rsp_tvalid,
   input  logic            rsp_tready,
   output logic [7:0]      rsp_tdata,
   output logic            rsp_tlast
);

   logic       wk_valid_ff, wk_valid_in;
   logic [3:0] idx_ff, idx_in;
   seq_type    seq_ff, seq_in;
   logic [3:0] cnt_ff, cnt_in;
   logic       out_valid_ff, out_valid_in;
   logic [7:0] out_byte_ff, out_byte_in;
   logic       out_last_ff, out_last_in;

   logic       slot;
   logic       emit;
   logic       at_last;
   logic       finishing;

   assign slot      = !out_valid_ff || rsp_tready;
   assign emit      = wk_valid_ff && slot;
   assign at_last   = (idx_ff == (cnt_ff - 4'd1));
   assign finishing = emit && at_last;
   assign take_ok   = !wk_valid_ff || finishing;

   assign status.busy      = wk_valid_ff;
   assign status.finishing = finishing;

   assign rsp_tvalid = out_valid_ff;
   assign rsp_tdata  = out_byte_ff;
   assign rsp_tlast  = out_last_ff;

   always_comb begin
      wk_valid_in = wk_valid_ff;
      idx_in      = idx_ff;
      seq_in      = seq_ff;
      cnt_in      = cnt_ff;
      if (finishing) begin
         wk_valid_in = 1'b0;
      end else if (emit) begin
         idx_in = idx_ff + 4'd1;
      end
      if (job_load) begin
         wk_valid_in = 1'b1;
         idx_in      = 4'd0;
         seq_in      = job.seq;
         cnt_in      = job.cnt;
      end
   end

   always_comb begin
      out_valid_in = out_valid_ff;
      out_byte_in  = out_byte_ff;
      out_last_in  = out_last_ff;
      if (emit) begin
         out_valid_in = 1'b1;
         out_byte_in  = seq_ff[idx_ff];
         out_last_in  = at_last;
      end else if (rsp_tready) begin
         out_valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wk_valid_ff  <= 1'b0;
         idx_ff       <= '0;
         out_valid_ff <= 1'b0;
      end else begin
         wk_valid_ff  <= wk_valid_in;
         idx_ff       <= idx_in;
         out_valid_ff <= out_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      seq_ff      <= seq_in;
      cnt_ff      <= cnt_in;
      out_byte_ff <= out_byte_in;
      out_last_ff <= out_last_in;
   end

endmodule

/* rtl/core/cat_stream_filter_unit.sv */
// Top level of the cat stream filter: config port, input stage and beat emitter.
// A kept beat loads the work register; its first byte then loads the output register.
// Throughput: one input beat per cycle while each byte renders to one output beat and
// the output is not stalled; a byte that expands to n output beats (up to 11 with a
// line number) holds the one-item work register; the input stalls while it is occupied.
// Reset clears config, line state (line start set, counter zero) and both valid flags.
module cat_stream_filter_unit
   import csf_pkg::*;
(
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  req_tvalid,
   output logic                  req_tready,
   input  logic [7:0]            req_tdata,   // [7:0] in_byte
   input  logic                  req_tuser,   // [0] first_of_file
   output logic                  rsp_tvalid,
   input  logic                  rsp_tready,
   output logic [7:0]            rsp_tdata,   // [7:0] out_byte
   output logic                  rsp_tlast,
   input  logic                  csr_psel,
   input  logic                  csr_penable,
   input  logic                  csr_pwrite,
   input  logic [CSR_ADDR_W-1:0] csr_paddr,
   input  logic [CSR_DATA_W-1:0] csr_pwdata,
   output logic [CSR_DATA_W-1:0] csr_prdata,
   output logic                  csr_pready
);

   cfg_type         cfg;
   job_type         job;
   logic            job_load;
   logic            take_ok;
   emit_status_type status;

   csf_csr u_csr (
      .clock       (clock),
      .reset       (reset),
      .csr_psel    (csr_psel),
      .csr_penable (csr_penable),
      .csr_pwrite  (csr_pwrite),
      .csr_paddr   (csr_paddr),
      .csr_pwdata  (csr_pwdata),
      .csr_prdata  (csr_prdata),
      .csr_pready  (csr_pready),
      .cfg         (cfg)
   );

   csf_front u_front (
      .clock      (clock),
      .reset      (reset),
      .cfg        (cfg),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .req_tuser  (req_tuser),
      .take_ok    (take_ok),
      .job_load   (job_load),
      .job        (job)
   );

   csf_emit u_emit (
      .clock      (clock),
      .reset      (reset),
      .job_load   (job_load),
      .job        (job),
      .take_ok    (take_ok),
      .status     (status),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata),
      .rsp_tlast  (rsp_tlast)
   );

`ifndef ASSERT_OFF
   // a kept beat always lands in the work register
   a_load_busy: assert property (@(posedge clock) disable iff (reset)
      job_load |=> status.busy)
      else $error("loaded item not held by emitter");

   // only a squeezed empty line may be accepted without producing work
   a_drop_squeeze: assert property (@(posedge clock) disable iff (reset)
      (req_tvalid && req_tready && !job_load) |->
      (cfg.squeeze_blank_lines && (req_tdata == CH_NL)))
      else $error("input beat dropped without squeeze");

   // input is only taken when the work register is free or drains this cycle
   a_ready_free: assert property (@(posedge clock) disable iff (reset)
      req_tready |-> (!status.busy || status.finishing))
      else $error("ready while emitter still holds an item");
`endif

endmodule

/* tb/tb_cat_stream_filter_unit.sv */
// Testbench for cat_stream_filter_unit: directed table, then random text files checked by a predictor.
module tb_cat_stream_filter_unit;
   import csf_pkg::*;

   timeunit 1ns;
   timeprecision 1ps;

   localparam int         REG_COUNT   = 6;
   localparam int         HOLD_CYCLES = 200;
   localparam int         CYCLE_LIMIT = 200000;
   localparam int         PHASES      = 8;
   localparam logic [19:0] NUM_SAT    = 20'd999999;

   // config bits, msb first: num_all, nonblank, squeeze, ends, tabs, nonprint
   localparam logic [5:0] CFG_PLAIN        = 6'b000000;
   localparam logic [5:0] CFG_SHOW         = 6'b000111;
   localparam logic [5:0] CFG_NUM_SQUEEZE  = 6'b101000;
   localparam logic [5:0] CFG_NUM_NONBLANK = 6'b110100;
   localparam logic [5:0] CFG_ALL_ON       = 6'b111111;

   typedef struct packed {
      logic [7:0] ch;
      logic       last;
   } char_beat_t;

   // n_typed == 0: expectation comes from the predictor
   typedef struct packed {
      cfg_type         cfg;
      logic [7:0]      in_byte;
      logic            first;
      logic [2:0]      n_typed;
      logic [3:0][7:0] typed;
   } stim_row_t;

   logic                  clock = 1'b0;
   logic                  reset;
   logic                  req_tvalid;
   logic                  req_tready;
   logic [7:0]            req_tdata;
   logic                  req_tuser;
   logic                  rsp_tvalid;
   logic                  rsp_tready;
   logic [7:0]            rsp_tdata;
   logic                  rsp_tlast;
   logic                  csr_psel;
   logic                  csr_penable;
   logic                  csr_pwrite;
   logic [CSR_ADDR_W-1:0] csr_paddr;
   logic [CSR_DATA_W-1:0] csr_pwdata;
   logic [CSR_DATA_W-1:0] csr_prdata;
   logic                  csr_pready;

   cat_stream_filter_unit dut (
      .clock       (clock),
      .reset       (reset),
      .req_tvalid  (req_tvalid),
      .req_tready  (req_tready),
      .req_tdata   (req_tdata),
      .req_tuser   (req_tuser),
      .rsp_tvalid  (rsp_tvalid),
      .rsp_tready  (rsp_tready),
      .rsp_tdata   (rsp_tdata),
      .rsp_tlast   (rsp_tlast),
      .csr_psel    (csr_psel),
      .csr_penable (csr_penable),
      .csr_pwrite  (csr_pwrite),
      .csr_paddr   (csr_paddr),
      .csr_pwdata  (csr_pwdata),
      .csr_prdata  (csr_prdata),
      .csr_pready  (csr_pready)
   );

   always begin
      #2 clock = 1'b1;
      #2 clock = 1'b0;
   end

   // predictor state
   cfg_type     shadow_cfg;
   logic        line_start;
   logic        prev_empty;
   logic [19:0] line_count;
   char_beat_t  model_out [SEQ_DEPTH];
   int          model_n;

   char_beat_t  expected_chars [$];
   int          mismatches = 0;
   int          cycles = 0;
   int          beats_sent = 0;
   int          req_gap_pct = 0;
   int          rsp_stall_pct = 0;
   bit          quiet_tail = 1'b0;
   bit          hold_off_req = 1'b0;
   bit          file_start = 1'b1;
   stim_row_t   dir_rows [$];

   function automatic void push_char(input logic [7:0] c);
      model_out[model_n] = '{ch: c, last: 1'b0};
      model_n++;
   endfunction

   // fills model_out with the characters one input byte produces
   function automatic void predict_output_chars(input logic [7:0] b, input logic first);
      logic       empty;
      logic       numbered;
      logic       lead;
      logic [7:0] lo;
      int         v;
      int         i;
      int         dig [6];
      model_n = 0;
      if (first || line_start) begin
         empty = (b == CH_NL);
         if (shadow_cfg.squeeze_blank_lines && prev_empty && empty) return;
         if (line_start) begin
            numbered = shadow_cfg.number_nonblank_lines ? !empty : shadow_cfg.number_all_lines;
            if (numbered) begin
               if (line_count < NUM_SAT) line_count++;
               v = line_count;
               for (i = 5; i >= 0; i--) begin
                  dig[i] = v % 10;
                  v = v / 10;
               end
               lead = 1'b1;
               for (i = 0; i < 6; i++) begin
                  if (lead && dig[i] == 0 && i < 5) begin
                     push_char(CH_SPACE);
                  end else begin
                     lead = 1'b0;
                     push_char(CH_ZERO + 8'(dig[i]));
                  end
               end
               push_char(CH_TAB);
            end
         end
         prev_empty = empty;
      end
      if (b == CH_TAB) begin
         if (shadow_cfg.show_tab_chars) begin
            push_char(CH_CARET);
            push_char(CH_I);
         end else begin
            push_char(b);
         end
      end else if (b == CH_NL) begin
         if (shadow_cfg.show_line_ends) push_char(CH_DOLLAR);
         push_char(b);
      end else if (!shadow_cfg.show_nonprinting) begin
         push_char(b);
      end else begin
         lo = b;
         if (b[7]) begin
            push_char(CH_M);
            push_char(CH_DASH);
            lo = {1'b0, b[6:0]};
         end
         if (lo < CTRL_TOP) begin
            push_char(CH_CARET);
            push_char(lo + CTRL_OFS);
         end else if (lo == CH_DEL) begin
            push_char(CH_CARET);
            push_char(CH_QMARK);
         end else begin
            push_char(lo);
         end
      end
      line_start = (b == CH_NL);
      model_out[model_n-1].last = 1'b1;
   endfunction

   function automatic logic cfg_field(input cfg_type c, input logic [2:0] idx);
      case (idx)
         REG_NUM_ALL:      return c.number_all_lines;
         REG_NUM_NONBLANK: return c.number_nonblank_lines;
         REG_SQUEEZE:      return c.squeeze_blank_lines;
         REG_SHOW_ENDS:    return c.show_line_ends;
         REG_SHOW_TABS:    return c.show_tab_chars;
         REG_NONPRINT:     return c.show_nonprinting;
         default:          return 1'b0;
      endcase
   endfunction

   function automatic logic take_first();
      logic f;
      f = file_start;
      file_start = 1'b0;
      return f;
   endfunction

   function automatic logic [7:0] pick_char();
      int r;
      r = $urandom_range(0, 15);
      if (r < 9)       return 8'($urandom_range(32, 126));
      else if (r < 10) return CH_TAB;
      else if (r < 12) return 8'($urandom_range(0, 31));
      else if (r < 13) return CH_DEL;
      else             return 8'($urandom_range(128, 255));
   endfunction

   // psel/penable are left high at the end so back-to-back transfers need one assignment per edge
   task automatic csr_write(input logic [2:0] idx, input logic [31:0] val);
      csr_psel    <= 1'b1;
      csr_penable <= 1'b0;
      csr_pwrite  <= 1'b1;
      csr_paddr   <= {idx, 2'b00};
      csr_pwdata  <= val;
      @(posedge clock);
      csr_penable <= 1'b1;
      @(posedge clock);
   endtask

   task automatic csr_read(input logic [2:0] idx, output logic [31:0] val);
      csr_psel    <= 1'b1;
      csr_penable <= 1'b0;
      csr_pwrite  <= 1'b0;
      csr_paddr   <= {idx, 2'b00};
      @(posedge clock);
      csr_penable <= 1'b1;
      @(negedge clock);
      val = csr_prdata;
      @(posedge clock);
   endtask

   // drain, then write every register (sometimes also an unused index) and read each back
   task automatic apply_settings(input cfg_type c);
      logic [31:0] wdata;
      logic [31:0] rdata;
      logic [2:0]  ri;
      int          idx;
      req_tvalid <= 1'b0;
      while (expected_chars.size() != 0) @(posedge clock);
      // a squeezed byte leaves no result to wait for
      repeat (6) @(posedge clock);
      for (idx = 0; idx < REG_COUNT; idx++) begin
         ri       = 3'(idx);
         wdata    = $urandom;
         wdata[0] = cfg_field(c, ri);
         csr_write(ri, wdata);
      end
      if ($urandom_range(0, 2) == 0) csr_write(3'(REG_COUNT + $urandom_range(0, 1)), $urandom);
      shadow_cfg = c;
      for (idx = 0; idx < REG_COUNT; idx++) begin
         ri = 3'(idx);
         csr_read(ri, rdata);
         if (rdata !== {31'b0, cfg_field(c, ri)}) begin
            $display("%0t: register %0d read expected %h, got %h",
                     $time, idx, {31'b0, cfg_field(c, ri)}, rdata);
            mismatches++;
         end
      end
      csr_psel    <= 1'b0;
      csr_penable <= 1'b0;
   endtask

   task automatic send_beat(input logic [7:0] b, input logic first,
                            input logic [2:0] n_typed, input logic [3:0][7:0] typed);
      int k;
      if (!quiet_tail && $urandom_range(0, 99) < req_gap_pct) begin
         req_tvalid <= 1'b0;
         repeat ($urandom_range(1, 9)) @(posedge clock);
      end
      req_tvalid <= 1'b1;
      req_tdata  <= b;
      req_tuser  <= first;
      do @(posedge clock); while (!req_tready);
      beats_sent++;
      predict_output_chars(b, first);
      if (n_typed == 0) begin
         for (k = 0; k < model_n; k++) expected_chars.push_back(model_out[k]);
      end else begin
         for (k = 0; k < n_typed; k++)
            expected_chars.push_back('{ch: typed[3-k], last: (k == n_typed - 1)});
      end
   endtask

   // output side: compare each beat against the oldest expectation
   always @(posedge clock) begin
      char_beat_t want;
      if (!reset && rsp_tvalid && rsp_tready) begin
         if (expected_chars.size() == 0) begin
            $display("%0t: unexpected beat, expected none, got %h last %b",
                     $time, rsp_tdata, rsp_tlast);
            mismatches++;
         end else begin
            want = expected_chars.pop_front();
            if (rsp_tdata !== want.ch) begin
               $display("%0t: out_byte expected %h, got %h", $time, want.ch, rsp_tdata);
               mismatches++;
            end
            if (rsp_tlast !== want.last) begin
               $display("%0t: last_of_run expected %b, got %b", $time, want.last, rsp_tlast);
               mismatches++;
            end
         end
      end
   end

   // receiver backpressure
   initial begin
      int k;
      rsp_tready <= 1'b0;
      forever begin
         @(posedge clock);
         if (hold_off_req) begin
            hold_off_req = 1'b0;
            rsp_tready <= 1'b0;
            for (k = 0; k < HOLD_CYCLES; k++) @(posedge clock);
         end else if (!quiet_tail && $urandom_range(0, 99) < rsp_stall_pct) begin
            rsp_tready <= 1'b0;
            repeat ($urandom_range(1, 9)) @(posedge clock);
         end else begin
            rsp_tready <= 1'b1;
         end
      end
   end

   always @(posedge clock) begin
      cycles++;
      if (cycles > CYCLE_LIMIT) begin
         $display("Mismatches found");
         $finish;
      end
   end

   initial begin
      stim_row_t row;
      cfg_type   cfg;
      int        ph;
      int        target;
      int        kind;
      int        len;

      reset       <= 1'b1;
      req_tvalid  <= 1'b0;
      req_tdata   <= '0;
      req_tuser   <= 1'b0;
      csr_psel    <= 1'b0;
      csr_penable <= 1'b0;
      csr_pwrite  <= 1'b0;
      csr_paddr   <= '0;
      csr_pwdata  <= '0;
      shadow_cfg  = '0;
      line_start  = 1'b1;
      prev_empty  = 1'b0;
      line_count  = '0;

      // reset values, plain pass-through
      dir_rows.push_back({CFG_PLAIN, 8'h41, 1'b1, 3'd1, {8'h41, 24'h0}});
      dir_rows.push_back({CFG_PLAIN, 8'h00, 1'b0, 3'd1, {8'h00, 24'h0}});
      dir_rows.push_back({CFG_PLAIN, 8'hFF, 1'b0, 3'd1, {8'hFF, 24'h0}});
      dir_rows.push_back({CFG_PLAIN, CH_TAB, 1'b0, 3'd1, {CH_TAB, 24'h0}});
      dir_rows.push_back({CFG_PLAIN, CH_NL, 1'b0, 3'd1, {CH_NL, 24'h0}});
      // every rendering branch
      dir_rows.push_back({CFG_SHOW, CH_TAB, 1'b1, 3'd2, {CH_CARET, CH_I, 16'h0}});
      dir_rows.push_back({CFG_SHOW, CH_NL, 1'b0, 3'd2, {CH_DOLLAR, CH_NL, 16'h0}});
      dir_rows.push_back({CFG_SHOW, 8'h00, 1'b0, 3'd2, {CH_CARET, 8'h40, 16'h0}});
      dir_rows.push_back({CFG_SHOW, 8'h1F, 1'b0, 3'd2, {CH_CARET, 8'h5F, 16'h0}});
      dir_rows.push_back({CFG_SHOW, CH_DEL, 1'b0, 3'd2, {CH_CARET, CH_QMARK, 16'h0}});
      dir_rows.push_back({CFG_SHOW, 8'h80, 1'b0, 3'd4, {CH_M, CH_DASH, CH_CARET, 8'h40}});
      dir_rows.push_back({CFG_SHOW, 8'h89, 1'b0, 3'd4, {CH_M, CH_DASH, CH_CARET, CH_I}});
      dir_rows.push_back({CFG_SHOW, 8'hA0, 1'b0, 3'd3, {CH_M, CH_DASH, CH_SPACE, 8'h0}});
      dir_rows.push_back({CFG_SHOW, 8'hFE, 1'b0, 3'd3, {CH_M, CH_DASH, 8'h7E, 8'h0}});
      dir_rows.push_back({CFG_SHOW, 8'hFF, 1'b0, 3'd4, {CH_M, CH_DASH, CH_CARET, CH_QMARK}});
      dir_rows.push_back({CFG_SHOW, 8'h7E, 1'b0, 3'd1, {8'h7E, 24'h0}});
      // new file after an unterminated one: no number; then squeeze of repeated blanks
      dir_rows.push_back({CFG_NUM_SQUEEZE, 8'h61, 1'b1, 3'd0, 32'h0});
      dir_rows.push_back({CFG_NUM_SQUEEZE, CH_NL, 1'b0, 3'd0, 32'h0});
      dir_rows.push_back({CFG_NUM_SQUEEZE, CH_NL, 1'b0, 3'd0, 32'h0});
      dir_rows.push_back({CFG_NUM_SQUEEZE, CH_NL, 1'b0, 3'd0, 32'h0});
      dir_rows.push_back({CFG_NUM_SQUEEZE, CH_NL, 1'b1, 3'd0, 32'h0});
      dir_rows.push_back({CFG_NUM_SQUEEZE, 8'h62, 1'b0, 3'd0, 32'h0});
      dir_rows.push_back({CFG_NUM_SQUEEZE, CH_NL, 1'b0, 3'd0, 32'h0});
      // nonblank numbering overrides all-lines numbering
      dir_rows.push_back({CFG_NUM_NONBLANK, CH_NL, 1'b0, 3'd0, 32'h0});
      dir_rows.push_back({CFG_NUM_NONBLANK, 8'h63, 1'b1, 3'd0, 32'h0});

      repeat (4) @(posedge clock);
      reset <= 1'b0;

      req_gap_pct   = 20;
      rsp_stall_pct = 20;
      foreach (dir_rows[i]) begin
         row = dir_rows[i];
         if (row.cfg != shadow_cfg) apply_settings(row.cfg);
         send_beat(row.in_byte, row.first, row.n_typed, row.typed);
      end

      for (ph = 0; ph < PHASES; ph++) begin
         if (ph == 0)      cfg = CFG_ALL_ON;
         else if (ph == 1) cfg = CFG_PLAIN;
         else              cfg = cfg_type'(6'($urandom_range(0, 63)));
         apply_settings(cfg);
         quiet_tail    = (ph >= PHASES - 2);
         req_gap_pct   = (ph % 3 == 0) ? 0 : 10 + 15 * (ph % 3);
         rsp_stall_pct = (ph % 4 == 1) ? 0 : 10 + 10 * (ph % 4);
         if (ph == 2) hold_off_req = 1'b1;
         file_start = 1'b1;
         target     = beats_sent + $urandom_range(22, 26);
         while (beats_sent < target) begin
            kind = $urandom_range(0, 9);
            if (kind < 2) begin
               send_beat(8'($urandom), 1'($urandom), 3'd0, 32'h0);
            end else begin
               // one line of text, possibly empty, possibly left unterminated
               len = (kind < 5) ? 0 : $urandom_range(1, 5);
               repeat (len) send_beat(pick_char(), take_first(), 3'd0, 32'h0);
               if ($urandom_range(0, 6) == 0) file_start = 1'b1;
               else send_beat(CH_NL, take_first(), 3'd0, 32'h0);
               if ($urandom_range(0, 4) == 0) file_start = 1'b1;
            end
         end
      end

      req_tvalid <= 1'b0;
      while (expected_chars.size() != 0) @(posedge clock);
      repeat (10) @(posedge clock);
      if (mismatches == 0) begin
         $display("No mismatches found");
      end else begin
         $display("Mismatches found");
      end
      $finish;
   end

endmodule
